[sv/htok_pkg.sv]
package htok_pkg;

  typedef enum logic [4:0] {
    ST_DATA, ST_TAGOPEN, ST_ENDTAGOPEN, ST_TAGNAME, ST_BEFAN, ST_AN, ST_AFTAN,
    ST_BEFAV, ST_AVDQ, ST_AVSQ, ST_AVUQ, ST_AFTAVQ, ST_SELFCLOSE, ST_BOGUS,
    ST_MARKUP, ST_CSTART, ST_CSTARTDASH, ST_COMMENT, ST_CENDDASH, ST_CEND,
    ST_CENDBANG, ST_DT, ST_BEFDN, ST_DN, ST_AFTDN
  } pstate_e;

  localparam logic [3:0] EV_CHAR  = 4'd0;
  localparam logic [3:0] EV_START = 4'd1;
  localparam logic [3:0] EV_ENDT  = 4'd2;
  localparam logic [3:0] EV_TNAME = 4'd3;
  localparam logic [3:0] EV_ATTR  = 4'd4;
  localparam logic [3:0] EV_ANAME = 4'd5;
  localparam logic [3:0] EV_AVAL  = 4'd6;
  localparam logic [3:0] EV_TEND  = 4'd7;
  localparam logic [3:0] EV_CBEG  = 4'd8;
  localparam logic [3:0] EV_CDATA = 4'd9;
  localparam logic [3:0] EV_CEND  = 4'd10;
  localparam logic [3:0] EV_DBEG  = 4'd11;
  localparam logic [3:0] EV_DNAME = 4'd12;
  localparam logic [3:0] EV_DEND  = 4'd13;
  localparam logic [3:0] EV_EOF   = 4'd14;

  localparam logic [7:0] REP_DATA = 8'hFD;
  localparam logic [7:0] REP_NAME = 8'hEF;
  localparam logic [7:0] CASE_OFS = 8'h20;
  localparam int unsigned KW_LEN  = 7;

  typedef struct packed {
    logic [3:0] tok;
    logic [7:0] dat;
    logic       flg;
    logic       lst;
  } evt_t;

  typedef struct packed {
    pstate_e     st;
    logic [2:0]  n;
    evt_t [3:0]  ev;
  } step_t;

  function automatic logic is_ws(logic [7:0] c);
    return (c == 8'd9) || (c == 8'd10) || (c == 8'd12) || (c == 8'd32);
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic [7:0] lc(logic [7:0] c);
    return ((c >= "A") && (c <= "Z")) ? c + CASE_OFS : c;
  endfunction

  function automatic logic [7:0] kw_byte(logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0: b = "d";
      3'd1: b = "o";
      3'd2: b = "c";
      3'd3: b = "t";
      3'd4: b = "y";
      3'd5: b = "p";
      default: b = "e";
    endcase
    return b;
  endfunction

  function automatic step_t put_ev(step_t r, logic [3:0] tok, logic [7:0] dat, logic flg);
    step_t o;
    o = r;
    if (o.n < 3'd4) begin
      o.ev[o.n[1:0]].tok = tok;
      o.ev[o.n[1:0]].dat = dat;
      o.ev[o.n[1:0]].flg = flg;
      o.ev[o.n[1:0]].lst = 1'b0;
      o.n = o.n + 3'd1;
    end
    return o;
  endfunction

  // One byte through the tokenizer; reprocessing in a new state is a further pass.
  function automatic step_t consume_f(pstate_e st_in, logic [7:0] c);
    step_t r;
    logic again;
    logic [7:0] nm;
    logic [7:0] rb;
    r = '0;
    r.st = st_in;
    again = 1'b1;
    nm = (c == 8'd0) ? REP_NAME : lc(c);
    rb = (c == 8'd0) ? REP_NAME : c;
    for (int p = 0; p < 4; p++) begin
      if (again) begin
        again = 1'b0;
        unique case (r.st)
          ST_TAGOPEN: begin
            if (c == "!") r.st = ST_MARKUP;
            else if (c == "/") r.st = ST_ENDTAGOPEN;
            else if (is_alpha(c)) begin
              r = put_ev(r, EV_START, 8'd0, 1'b0); r.st = ST_TAGNAME; again = 1'b1;
            end else if (c == "?") begin
              r = put_ev(r, EV_CBEG, 8'd0, 1'b0); r.st = ST_BOGUS; again = 1'b1;
            end else begin
              r = put_ev(r, EV_CHAR, "<", 1'b0); r.st = ST_DATA; again = 1'b1;
            end
          end
          ST_ENDTAGOPEN: begin
            if (is_alpha(c)) begin
              r = put_ev(r, EV_ENDT, 8'd0, 1'b0); r.st = ST_TAGNAME; again = 1'b1;
            end else if (c == ">") r.st = ST_DATA;
            else begin
              r = put_ev(r, EV_CBEG, 8'd0, 1'b0); r.st = ST_BOGUS; again = 1'b1;
            end
          end
          ST_TAGNAME: begin
            if (is_ws(c)) r.st = ST_BEFAN;
            else if (c == "/") r.st = ST_SELFCLOSE;
            else if (c == ">") begin
              r = put_ev(r, EV_TEND, 8'd0, 1'b0); r.st = ST_DATA;
            end else r = put_ev(r, EV_TNAME, nm, 1'b0);
          end
          ST_BEFAN: begin
            if (is_ws(c)) r.st = ST_BEFAN;
            else if ((c == "/") || (c == ">")) begin
              r.st = ST_AFTAN; again = 1'b1;
            end else if (c == "=") begin
              r = put_ev(r, EV_ATTR, 8'd0, 1'b0);
              r = put_ev(r, EV_ANAME, "=", 1'b0);
              r.st = ST_AN;
            end else begin
              r = put_ev(r, EV_ATTR, 8'd0, 1'b0); r.st = ST_AN; again = 1'b1;
            end
          end
          ST_AN: begin
            if (is_ws(c) || (c == "/") || (c == ">")) begin
              r.st = ST_AFTAN; again = 1'b1;
            end else if (c == "=") r.st = ST_BEFAV;
            else r = put_ev(r, EV_ANAME, nm, 1'b0);
          end
          ST_AFTAN: begin
            if (is_ws(c)) r.st = ST_AFTAN;
            else if (c == "/") r.st = ST_SELFCLOSE;
            else if (c == "=") r.st = ST_BEFAV;
            else if (c == ">") begin
              r = put_ev(r, EV_TEND, 8'd0, 1'b0); r.st = ST_DATA;
            end else begin
              r = put_ev(r, EV_ATTR, 8'd0, 1'b0); r.st = ST_AN; again = 1'b1;
            end
          end
          ST_BEFAV: begin
            if (is_ws(c)) r.st = ST_BEFAV;
            else if (c == "\"") r.st = ST_AVDQ;
            else if (c == "'") r.st = ST_AVSQ;
            else if (c == ">") begin
              r = put_ev(r, EV_TEND, 8'd0, 1'b0); r.st = ST_DATA;
            end else begin
              r.st = ST_AVUQ; again = 1'b1;
            end
          end
          ST_AVDQ: begin
            if (c == "\"") r.st = ST_AFTAVQ;
            else r = put_ev(r, EV_AVAL, rb, 1'b0);
          end
          ST_AVSQ: begin
            if (c == "'") r.st = ST_AFTAVQ;
            else r = put_ev(r, EV_AVAL, rb, 1'b0);
          end
          ST_AVUQ: begin
            if (is_ws(c)) r.st = ST_BEFAN;
            else if (c == ">") begin
              r = put_ev(r, EV_TEND, 8'd0, 1'b0); r.st = ST_DATA;
            end else r = put_ev(r, EV_AVAL, rb, 1'b0);
          end
          ST_AFTAVQ: begin
            if (is_ws(c)) r.st = ST_BEFAN;
            else if (c == "/") r.st = ST_SELFCLOSE;
            else if (c == ">") begin
              r = put_ev(r, EV_TEND, 8'd0, 1'b0); r.st = ST_DATA;
            end else begin
              r.st = ST_BEFAN; again = 1'b1;
            end
          end
          ST_SELFCLOSE: begin
            if (c == ">") begin
              r = put_ev(r, EV_TEND, 8'd0, 1'b1); r.st = ST_DATA;
            end else begin
              r.st = ST_BEFAN; again = 1'b1;
            end
          end
          ST_MARKUP: begin
            r = put_ev(r, EV_CBEG, 8'd0, 1'b0); r.st = ST_BOGUS; again = 1'b1;
          end
          ST_BOGUS: begin
            if (c == ">") begin
              r = put_ev(r, EV_CEND, 8'd0, 1'b0); r.st = ST_DATA;
            end else r = put_ev(r, EV_CDATA, rb, 1'b0);
          end
          ST_CSTART: begin
            if (c == "-") r.st = ST_CSTARTDASH;
            else if (c == ">") begin
              r = put_ev(r, EV_CEND, 8'd0, 1'b0); r.st = ST_DATA;
            end else begin
              r.st = ST_COMMENT; again = 1'b1;
            end
          end
          ST_CSTARTDASH: begin
            if (c == "-") r.st = ST_CEND;
            else if (c == ">") begin
              r = put_ev(r, EV_CEND, 8'd0, 1'b0); r.st = ST_DATA;
            end else begin
              r = put_ev(r, EV_CDATA, "-", 1'b0); r.st = ST_COMMENT; again = 1'b1;
            end
          end
          ST_COMMENT: begin
            if (c == "-") r.st = ST_CENDDASH;
            else r = put_ev(r, EV_CDATA, rb, 1'b0);
          end
          ST_CENDDASH: begin
            if (c == "-") r.st = ST_CEND;
            else begin
              r = put_ev(r, EV_CDATA, "-", 1'b0); r.st = ST_COMMENT; again = 1'b1;
            end
          end
          ST_CEND: begin
            if (c == ">") begin
              r = put_ev(r, EV_CEND, 8'd0, 1'b0); r.st = ST_DATA;
            end else if (c == "!") r.st = ST_CENDBANG;
            else if (c == "-") r = put_ev(r, EV_CDATA, "-", 1'b0);
            else begin
              r = put_ev(r, EV_CDATA, "-", 1'b0);
              r = put_ev(r, EV_CDATA, "-", 1'b0);
              r.st = ST_COMMENT; again = 1'b1;
            end
          end
          ST_CENDBANG: begin
            if (c == ">") begin
              r = put_ev(r, EV_CEND, 8'd0, 1'b0); r.st = ST_DATA;
            end else begin
              r = put_ev(r, EV_CDATA, "-", 1'b0);
              r = put_ev(r, EV_CDATA, "-", 1'b0);
              r = put_ev(r, EV_CDATA, "!", 1'b0);
              if (c == "-") r.st = ST_CENDDASH;
              else begin
                r.st = ST_COMMENT; again = 1'b1;
              end
            end
          end
          ST_DT: begin
            if (is_ws(c)) r.st = ST_BEFDN;
            else if (c == ">") begin
              r = put_ev(r, EV_DEND, 8'd0, 1'b1); r.st = ST_DATA;
            end else begin
              r.st = ST_BEFDN; again = 1'b1;
            end
          end
          ST_BEFDN: begin
            if (is_ws(c)) r.st = ST_BEFDN;
            else if (c == ">") begin
              r = put_ev(r, EV_DEND, 8'd0, 1'b1); r.st = ST_DATA;
            end else begin
              r = put_ev(r, EV_DNAME, nm, 1'b0); r.st = ST_DN;
            end
          end
          ST_DN: begin
            if (is_ws(c)) r.st = ST_AFTDN;
            else if (c == ">") begin
              r = put_ev(r, EV_DEND, 8'd0, 1'b0); r.st = ST_DATA;
            end else r = put_ev(r, EV_DNAME, nm, 1'b0);
          end
          ST_AFTDN: begin
            if (c == ">") begin
              r = put_ev(r, EV_DEND, 8'd0, 1'b0); r.st = ST_DATA;
            end
          end
          default: begin
            if (c == "<") r.st = ST_TAGOPEN;
            else begin
              r = put_ev(r, EV_CHAR, (c == 8'd0) ? REP_DATA : c, 1'b0);
              r.st = ST_DATA;
            end
          end
        endcase
      end
    end
    return r;
  endfunction

  // End of input from a state that holds no undecided lookahead bytes.
  function automatic step_t eof_f(pstate_e st_in);
    step_t r;
    r = '0;
    unique case (st_in)
      ST_MARKUP: begin
        r = put_ev(r, EV_CBEG, 8'd0, 1'b0);
        r = put_ev(r, EV_CEND, 8'd0, 1'b0);
      end
      ST_TAGOPEN: r = put_ev(r, EV_CHAR, "<", 1'b0);
      ST_ENDTAGOPEN: begin
        r = put_ev(r, EV_CHAR, "<", 1'b0);
        r = put_ev(r, EV_CHAR, "/", 1'b0);
      end
      ST_BOGUS, ST_CSTART, ST_CSTARTDASH, ST_COMMENT, ST_CENDDASH, ST_CEND,
      ST_CENDBANG: r = put_ev(r, EV_CEND, 8'd0, 1'b0);
      ST_DT, ST_BEFDN, ST_DN, ST_AFTDN: r = put_ev(r, EV_DEND, 8'd0, 1'b1);
      default: r = r;
    endcase
    r = put_ev(r, EV_EOF, 8'd0, 1'b0);
    r.st = ST_DATA;
    return r;
  endfunction

endpackage

[sv/html_tokenizer_byte_fsm.sv]
// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/tready         tuser: kind; tdata: data_byte
// m_axis    out  m_axis_tvalid/tready/tlast   tuser: token_event; tdata: event_byte, event_flag
//
// A byte goes from the input register through one tokenizer step into an 8-entry event
// queue, then into the output register; one byte per cycle while the queue has room.
// The output drains one event per cycle while m_axis_tready_i is high. While input stalls, a
// failed or cut-off lookahead after "<!" replays held bytes, one per cycle if queue has room.
// Reset (rst_ni low, asynchronous) returns the tokenizer to the data state.
module html_tokenizer_byte_fsm
  import htok_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic [0:0]  s_axis_tuser_i,   // [0] kind
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [7:0] event_byte, [8] event_flag
  output logic [3:0]  m_axis_tuser_o,   // [3:0] token_event
  output logic        m_axis_tlast_o
);

  pstate_e    st_q, st_d;
  logic [2:0] la_cnt_q, la_cnt_d;
  logic [7:0] la_buf_q [KW_LEN];
  logic       la_wr;
  logic       eof_done_q, eof_done_d;
  logic       rp_active_q, rp_active_d;
  logic       rp_eof_q, rp_eof_d;
  logic [2:0] rp_idx_q, rp_idx_d;
  logic [2:0] rp_n_q, rp_n_d;
  logic       in_valid_q;
  logic       in_kind_q;
  logic [7:0] in_byte_q;
  evt_t       fifo_q [8];
  logic [2:0] wr_q, rd_q;
  logic [3:0] cnt_q;
  logic       out_valid_q;
  evt_t       out_q;

  step_t      r;
  logic       space, fire, done, mark_tail, in_take, rel, out_load;
  logic       first_dash;
  logic [7:0] c;

  assign space = (cnt_q <= 4'd4);
  assign c = in_byte_q;
  assign first_dash = (la_cnt_q == 3'd0) ? (c == "-") : (la_buf_q[0] == "-");

  always_comb begin
    r = '0;
    r.st = st_q;
    fire = 1'b0;
    done = 1'b0;
    in_take = 1'b0;
    la_wr = 1'b0;
    la_cnt_d = la_cnt_q;
    eof_done_d = eof_done_q;
    rp_active_d = rp_active_q;
    rp_eof_d = rp_eof_q;
    rp_idx_d = rp_idx_q;
    rp_n_d = rp_n_q;
    if (rp_active_q) begin
      if (space) begin
        fire = 1'b1;
        if (rp_idx_q < rp_n_q) begin
          r = consume_f(st_q, la_buf_q[rp_idx_q]);
          rp_idx_d = rp_idx_q + 3'd1;
          done = (rp_idx_d == rp_n_q) && !rp_eof_q;
        end else begin
          r = eof_f(st_q);
          eof_done_d = 1'b1;
          done = 1'b1;
        end
        if (done) rp_active_d = 1'b0;
      end
    end else if (in_valid_q && space) begin
      fire = 1'b1;
      in_take = 1'b1;
      if (eof_done_q) begin
        done = 1'b1;
      end else if (in_kind_q) begin
        if ((st_q == ST_MARKUP) && (la_cnt_q != 3'd0)) begin
          r = put_ev(r, EV_CBEG, 8'd0, 1'b0);
          r.st = ST_BOGUS;
          rp_active_d = 1'b1;
          rp_eof_d = 1'b1;
          rp_idx_d = 3'd0;
          rp_n_d = la_cnt_q;
          la_cnt_d = 3'd0;
        end else begin
          r = eof_f(st_q);
          eof_done_d = 1'b1;
          done = 1'b1;
        end
      end else if (st_q == ST_MARKUP) begin
        la_wr = 1'b1;
        done = 1'b1;
        if (first_dash && (la_cnt_q == 3'd0)) begin
          la_cnt_d = 3'd1;
        end else if (first_dash && (c == "-")) begin
          r = put_ev(r, EV_CBEG, 8'd0, 1'b0);
          r.st = ST_CSTART;
          la_cnt_d = 3'd0;
        end else if (!first_dash && (lc(c) == kw_byte(la_cnt_q))) begin
          if (la_cnt_q == 3'(KW_LEN - 1)) begin
            r = put_ev(r, EV_DBEG, 8'd0, 1'b0);
            r.st = ST_DT;
            la_cnt_d = 3'd0;
          end else begin
            la_cnt_d = la_cnt_q + 3'd1;
          end
        end else begin
          // No match: the held bytes and this one become a bogus comment.
          r = put_ev(r, EV_CBEG, 8'd0, 1'b0);
          r.st = ST_BOGUS;
          done = 1'b0;
          rp_active_d = 1'b1;
          rp_eof_d = 1'b0;
          rp_idx_d = 3'd0;
          rp_n_d = la_cnt_q + 3'd1;
          la_cnt_d = 3'd0;
        end
      end else begin
        r = consume_f(st_q, c);
        done = 1'b1;
      end
    end
    if (done && (r.n != 3'd0)) r.ev[r.n[1:0] - 2'd1].lst = 1'b1;
    mark_tail = done && rp_active_q && (r.n == 3'd0);
    st_d = fire ? r.st : st_q;
  end

  // During a replay the newest queued event may still turn out to be the final one.
  assign rel = (cnt_q != 4'd0) && !(rp_active_q && (cnt_q == 4'd1));
  assign out_load = rel && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || in_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_DATA;
      la_cnt_q <= 3'd0;
      eof_done_q <= 1'b0;
      rp_active_q <= 1'b0;
      rp_eof_q <= 1'b0;
      rp_idx_q <= 3'd0;
      rp_n_q <= 3'd0;
      in_valid_q <= 1'b0;
      wr_q <= 3'd0;
      rd_q <= 3'd0;
      cnt_q <= 4'd0;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      la_cnt_q <= la_cnt_d;
      eof_done_q <= eof_done_d;
      rp_active_q <= rp_active_d;
      rp_eof_q <= rp_eof_d;
      rp_idx_q <= rp_idx_d;
      rp_n_q <= rp_n_d;
      if (s_axis_tready_o) in_valid_q <= s_axis_tvalid_i;
      if (fire) wr_q <= wr_q + r.n;
      if (out_load) rd_q <= rd_q + 3'd1;
      cnt_q <= cnt_q + (fire ? {1'b0, r.n} : 4'd0) - {3'd0, out_load};
      if (out_load) out_valid_q <= 1'b1;
      else if (m_axis_tready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_kind_q <= s_axis_tuser_i[0];
      in_byte_q <= s_axis_tdata_i;
    end
    if (la_wr) la_buf_q[la_cnt_q] <= c;
    if (fire) begin
      for (int i = 0; i < 4; i++) begin
        if (3'(i) < r.n) fifo_q[wr_q + 3'(i)] <= r.ev[i];
      end
    end
    if (mark_tail) fifo_q[wr_q - 3'd1].lst <= 1'b1;
    if (out_load) out_q <= fifo_q[rd_q];
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'd0, out_q.flg, out_q.dat};
  assign m_axis_tuser_o  = out_q.tok;
  assign m_axis_tlast_o  = out_q.lst;

endmodule

[bench/html_tokenizer_byte_fsm_checker.sv]
`timescale 1ns / 1ps

module html_tokenizer_byte_fsm_checker
  import htok_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [7:0]  s_axis_tdata_i,
  input  logic [0:0]  s_axis_tuser_i,
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [15:0] m_axis_tdata_i,
  input  logic [3:0]  m_axis_tuser_i,
  input  logic        m_axis_tlast_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          events_seen_o
);

  pstate_e    tok_state;
  logic [7:0] held_bytes [7];
  int         held_count;
  logic       input_closed;
  evt_t       pending_events [$];
  evt_t       item_events [$];

  assign pending_o = pending_events.size();

  function automatic logic space_byte(logic [7:0] c);
    return (c == 8'd9) || (c == 8'd10) || (c == 8'd12) || (c == 8'd32);
  endfunction

  function automatic logic letter_byte(logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic [7:0] lower_byte(logic [7:0] c);
    return ((c >= "A") && (c <= "Z")) ? c + 8'h20 : c;
  endfunction

  task automatic emit(logic [3:0] tok, logic [7:0] dat, logic flg);
    evt_t e;
    e.tok = tok;
    e.dat = dat;
    e.flg = flg;
    e.lst = 1'b0;
    if (item_events.size() < 12) item_events.insert(item_events.size(), e);
  endtask

  task automatic tokenize_byte(logic [7:0] c);
    logic again;
    logic [7:0] nm;
    logic [7:0] rb;
    again = 1'b1;
    nm = (c == 8'd0) ? REP_NAME : lower_byte(c);
    rb = (c == 8'd0) ? REP_NAME : c;
    while (again) begin
      again = 1'b0;
      case (tok_state)
        ST_TAGOPEN: begin
          if (c == "!") begin
            tok_state = ST_MARKUP; held_count = 0;
          end else if (c == "/") tok_state = ST_ENDTAGOPEN;
          else if (letter_byte(c)) begin
            emit(EV_START, 0, 0); tok_state = ST_TAGNAME; again = 1;
          end else if (c == "?") begin
            emit(EV_CBEG, 0, 0); tok_state = ST_BOGUS; again = 1;
          end else begin
            emit(EV_CHAR, "<", 0); tok_state = ST_DATA; again = 1;
          end
        end
        ST_ENDTAGOPEN: begin
          if (letter_byte(c)) begin
            emit(EV_ENDT, 0, 0); tok_state = ST_TAGNAME; again = 1;
          end else if (c == ">") tok_state = ST_DATA;
          else begin
            emit(EV_CBEG, 0, 0); tok_state = ST_BOGUS; again = 1;
          end
        end
        ST_TAGNAME: begin
          if (space_byte(c)) tok_state = ST_BEFAN;
          else if (c == "/") tok_state = ST_SELFCLOSE;
          else if (c == ">") begin
            emit(EV_TEND, 0, 0); tok_state = ST_DATA;
          end else emit(EV_TNAME, nm, 0);
        end
        ST_BEFAN: begin
          if (space_byte(c)) ;
          else if (c == "/" || c == ">") begin
            tok_state = ST_AFTAN; again = 1;
          end else if (c == "=") begin
            emit(EV_ATTR, 0, 0); emit(EV_ANAME, "=", 0); tok_state = ST_AN;
          end else begin
            emit(EV_ATTR, 0, 0); tok_state = ST_AN; again = 1;
          end
        end
        ST_AN: begin
          if (space_byte(c) || c == "/" || c == ">") begin
            tok_state = ST_AFTAN; again = 1;
          end else if (c == "=") tok_state = ST_BEFAV;
          else emit(EV_ANAME, nm, 0);
        end
        ST_AFTAN: begin
          if (space_byte(c)) ;
          else if (c == "/") tok_state = ST_SELFCLOSE;
          else if (c == "=") tok_state = ST_BEFAV;
          else if (c == ">") begin
            emit(EV_TEND, 0, 0); tok_state = ST_DATA;
          end else begin
            emit(EV_ATTR, 0, 0); tok_state = ST_AN; again = 1;
          end
        end
        ST_BEFAV: begin
          if (space_byte(c)) ;
          else if (c == "\"") tok_state = ST_AVDQ;
          else if (c == "'") tok_state = ST_AVSQ;
          else if (c == ">") begin
            emit(EV_TEND, 0, 0); tok_state = ST_DATA;
          end else begin
            tok_state = ST_AVUQ; again = 1;
          end
        end
        ST_AVDQ, ST_AVSQ: begin
          if (c == ((tok_state == ST_AVDQ) ? "\"" : "'")) tok_state = ST_AFTAVQ;
          else emit(EV_AVAL, rb, 0);
        end
        ST_AVUQ: begin
          if (space_byte(c)) tok_state = ST_BEFAN;
          else if (c == ">") begin
            emit(EV_TEND, 0, 0); tok_state = ST_DATA;
          end else emit(EV_AVAL, rb, 0);
        end
        ST_AFTAVQ: begin
          if (space_byte(c)) tok_state = ST_BEFAN;
          else if (c == "/") tok_state = ST_SELFCLOSE;
          else if (c == ">") begin
            emit(EV_TEND, 0, 0); tok_state = ST_DATA;
          end else begin
            tok_state = ST_BEFAN; again = 1;
          end
        end
        ST_SELFCLOSE: begin
          if (c == ">") begin
            emit(EV_TEND, 0, 1); tok_state = ST_DATA;
          end else begin
            tok_state = ST_BEFAN; again = 1;
          end
        end
        ST_MARKUP: begin
          emit(EV_CBEG, 0, 0); tok_state = ST_BOGUS; again = 1;
        end
        ST_BOGUS: begin
          if (c == ">") begin
            emit(EV_CEND, 0, 0); tok_state = ST_DATA;
          end else emit(EV_CDATA, rb, 0);
        end
        ST_CSTART: begin
          if (c == "-") tok_state = ST_CSTARTDASH;
          else if (c == ">") begin
            emit(EV_CEND, 0, 0); tok_state = ST_DATA;
          end else begin
            tok_state = ST_COMMENT; again = 1;
          end
        end
        ST_CSTARTDASH: begin
          if (c == "-") tok_state = ST_CEND;
          else if (c == ">") begin
            emit(EV_CEND, 0, 0); tok_state = ST_DATA;
          end else begin
            emit(EV_CDATA, "-", 0); tok_state = ST_COMMENT; again = 1;
          end
        end
        ST_COMMENT: begin
          if (c == "-") tok_state = ST_CENDDASH;
          else emit(EV_CDATA, rb, 0);
        end
        ST_CENDDASH: begin
          if (c == "-") tok_state = ST_CEND;
          else begin
            emit(EV_CDATA, "-", 0); tok_state = ST_COMMENT; again = 1;
          end
        end
        ST_CEND: begin
          if (c == ">") begin
            emit(EV_CEND, 0, 0); tok_state = ST_DATA;
          end else if (c == "!") tok_state = ST_CENDBANG;
          else if (c == "-") emit(EV_CDATA, "-", 0);
          else begin
            emit(EV_CDATA, "-", 0); emit(EV_CDATA, "-", 0);
            tok_state = ST_COMMENT; again = 1;
          end
        end
        ST_CENDBANG: begin
          if (c == ">") begin
            emit(EV_CEND, 0, 0); tok_state = ST_DATA;
          end else begin
            emit(EV_CDATA, "-", 0); emit(EV_CDATA, "-", 0); emit(EV_CDATA, "!", 0);
            if (c == "-") tok_state = ST_CENDDASH;
            else begin
              tok_state = ST_COMMENT; again = 1;
            end
          end
        end
        ST_DT: begin
          if (space_byte(c)) tok_state = ST_BEFDN;
          else if (c == ">") begin
            emit(EV_DEND, 0, 1); tok_state = ST_DATA;
          end else begin
            tok_state = ST_BEFDN; again = 1;
          end
        end
        ST_BEFDN: begin
          if (space_byte(c)) ;
          else if (c == ">") begin
            emit(EV_DEND, 0, 1); tok_state = ST_DATA;
          end else begin
            emit(EV_DNAME, nm, 0); tok_state = ST_DN;
          end
        end
        ST_DN: begin
          if (space_byte(c)) tok_state = ST_AFTDN;
          else if (c == ">") begin
            emit(EV_DEND, 0, 0); tok_state = ST_DATA;
          end else emit(EV_DNAME, nm, 0);
        end
        ST_AFTDN: begin
          if (c == ">") begin
            emit(EV_DEND, 0, 0); tok_state = ST_DATA;
          end
        end
        default: begin
          tok_state = ST_DATA;
          if (c == "<") tok_state = ST_TAGOPEN;
          else emit(EV_CHAR, (c == 8'd0) ? REP_DATA : c, 0);
        end
      endcase
    end
  endtask

  // Undecided bytes after "<!" turn into the body of a bogus comment.
  task automatic flush_held_as_bogus();
    logic [7:0] copy [7];
    int n;
    n = held_count;
    for (int i = 0; i < 7; i++) copy[i] = held_bytes[i];
    held_count = 0;
    emit(EV_CBEG, 0, 0);
    tok_state = ST_BOGUS;
    for (int i = 0; i < n; i++) tokenize_byte(copy[i]);
  endtask

  task automatic markup_byte(logic [7:0] c);
    logic match;
    match = 1'b1;
    if (held_count >= 7) begin
      flush_held_as_bogus();
      tokenize_byte(c);
    end else begin
      held_bytes[held_count] = c;
      held_count++;
      if (held_bytes[0] == "-") begin
        if (held_count >= 2) begin
          if (held_bytes[1] == "-") begin
            held_count = 0; emit(EV_CBEG, 0, 0); tok_state = ST_CSTART;
          end else flush_held_as_bogus();
        end
      end else begin
        for (int i = 0; i < held_count; i++)
          if (lower_byte(held_bytes[i]) != 8'("doctype" >> (8 * (6 - i)))) match = 1'b0;
        if (!match) flush_held_as_bogus();
        else if (held_count == 7) begin
          held_count = 0; emit(EV_DBEG, 0, 0); tok_state = ST_DT;
        end
      end
    end
  endtask

  task automatic close_input();
    if (tok_state == ST_MARKUP) flush_held_as_bogus();
    case (tok_state)
      ST_TAGOPEN: emit(EV_CHAR, "<", 0);
      ST_ENDTAGOPEN: begin
        emit(EV_CHAR, "<", 0); emit(EV_CHAR, "/", 0);
      end
      ST_BOGUS, ST_CSTART, ST_CSTARTDASH, ST_COMMENT, ST_CENDDASH, ST_CEND,
      ST_CENDBANG: emit(EV_CEND, 0, 0);
      ST_DT, ST_BEFDN, ST_DN, ST_AFTDN: emit(EV_DEND, 0, 1);
      default: ;
    endcase
    tok_state = ST_DATA;
    emit(EV_EOF, 0, 0);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    evt_t want;
    if (!rst_ni) begin
      tok_state = ST_DATA;
      held_count = 0;
      input_closed = 1'b0;
      pending_events.delete();
      fail_count_o = 0;
      events_seen_o = 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_i && !input_closed) begin
        item_events.delete();
        if (s_axis_tuser_i[0]) begin
          input_closed = 1'b1;
          close_input();
        end else if (tok_state == ST_MARKUP) markup_byte(s_axis_tdata_i);
        else tokenize_byte(s_axis_tdata_i);
        if (item_events.size() > 0) item_events[item_events.size() - 1].lst = 1'b1;
        foreach (item_events[i]) pending_events.insert(pending_events.size(), item_events[i]);
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        events_seen_o++;
        if (pending_events.size() == 0) begin
          $error("unexpected token event %0d", m_axis_tuser_i);
          fail_count_o++;
        end else begin
          want = pending_events.pop_front();
          if (m_axis_tuser_i != want.tok) begin
            $error("token_event: expected %0d, actual %0d", want.tok, m_axis_tuser_i);
            fail_count_o++;
          end
          if (m_axis_tdata_i[7:0] != want.dat) begin
            $error("event_byte: expected %0h, actual %0h", want.dat, m_axis_tdata_i[7:0]);
            fail_count_o++;
          end
          if (m_axis_tdata_i[8] != want.flg) begin
            $error("event_flag: expected %0d, actual %0d", want.flg, m_axis_tdata_i[8]);
            fail_count_o++;
          end
          if (m_axis_tlast_i != want.lst) begin
            $error("last: expected %0d, actual %0d", want.lst, m_axis_tlast_i);
            fail_count_o++;
          end
        end
      end
    end
  end

endmodule

[bench/html_tokenizer_byte_fsm_test.sv]
`timescale 1ns / 1ps

module html_tokenizer_byte_fsm_test;
  import htok_pkg::*;

  localparam int STALL_LIMIT = 4000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = '0;
  logic [0:0]  s_axis_tuser_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [15:0] m_axis_tdata_o;
  logic [3:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;
  int          fail_count;
  int          pending;
  int          events_seen;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          items_sent;
  int          quiet_cycles = 0;
  logic [7:0]  text_q [$];

  always #5 clk_i = ~clk_i;

  html_tokenizer_byte_fsm DUT (.*);

  html_tokenizer_byte_fsm_checker checker_i (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i, .s_axis_tready_i(s_axis_tready_o), .s_axis_tdata_i, .s_axis_tuser_i,
    .m_axis_tvalid_i(m_axis_tvalid_o), .m_axis_tready_i, .m_axis_tdata_i(m_axis_tdata_o),
    .m_axis_tuser_i(m_axis_tuser_o), .m_axis_tlast_i(m_axis_tlast_o),
    .fail_count_o(fail_count), .pending_o(pending), .events_seen_o(events_seen)
  );

  always @(posedge clk_i) begin
    if (rst_ni) m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("html_tokenizer_byte_fsm_test: done, errors");
      $finish;
    end
  end

  task automatic send_item(logic kind, logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i <= kind;
    s_axis_tdata_i <= b;
    @(posedge clk_i iff s_axis_tready_o);
    items_sent++;
  endtask

  task automatic add_byte(logic [7:0] b);
    text_q.insert(text_q.size(), b);
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  task automatic add_name();
    int n;
    n = $urandom_range(1, 5);
    for (int i = 0; i < n; i++)
      add_byte($urandom_range(1) ? 8'($urandom_range("a", "z"))
                                 : 8'($urandom_range("A", "Z")));
  endtask

  task automatic add_noise(int n);
    for (int i = 0; i < n; i++) add_byte(8'($urandom_range(255)));
  endtask

  // Mostly well-formed markup with random content, plus some broken pieces.
  task automatic add_fragment();
    case ($urandom_range(9))
      0: begin
        add_name();
        add_text($urandom_range(1) ? " " : "\t");
        if ($urandom_range(3) == 0) add_byte(8'd0);
      end
      1, 2: begin
        add_text("<");
        add_name();
        repeat ($urandom_range(3)) begin
          add_text($urandom_range(1) ? " " : "\n");
          if ($urandom_range(5) == 0) add_text("=");
          add_name();
          case ($urandom_range(3))
            0: ;
            1: begin add_text("=\""); add_noise($urandom_range(2)); add_text("\""); end
            2: begin add_text("='"); add_name(); add_text("'"); end
            default: begin add_text("="); add_name(); end
          endcase
        end
        add_text($urandom_range(2) == 0 ? "/>" : ">");
      end
      3: begin add_text("</"); add_name(); add_text(">"); end
      4: begin
        add_text("<!--");
        repeat ($urandom_range(4)) begin
          case ($urandom_range(3))
            0: add_text("-");
            1: add_text("--!");
            2: add_byte(8'd0);
            default: add_name();
          endcase
        end
        add_text($urandom_range(2) == 0 ? "--!>" : "-->");
      end
      5: begin
        add_text($urandom_range(1) ? "<!DocType" : "<!doctype");
        if ($urandom_range(3) != 0) begin
          add_text(" "); add_name();
          if ($urandom_range(1)) add_text(" x");
        end
        add_text(">");
      end
      6: begin
        add_text($urandom_range(1) ? "<?" : "<!");
        add_name(); add_text(">");
      end
      7: add_text($urandom_range(1) ? "<!-x" : "<!doc-");
      8: add_text($urandom_range(1) ? "</ " : "< ");
      default: add_noise($urandom_range(1, 6));
    endcase
  endtask

  initial begin
    send_idle_pct = 0;
    recv_stall_pct = 0;
    items_sent = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: quoting, self-close, NUL replacements, empty comment, doctype
    // without name, bogus after a failed markup match, stray byte values.
    add_text("<A x=\"");
    add_byte(8'd0);
    add_text("\"/>");
    add_byte(8'd0);
    add_byte(8'hFF);
    add_text("<1<!--><!Dx><!DOCTYPE>");
    foreach (text_q[i]) send_item(1'b0, text_q[i]);
    text_q.delete();

    // Let everything drain before the random part.
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    @(posedge clk_i);

    while (text_q.size() < 200) add_fragment();
    for (int i = 0; i < text_q.size(); i++) begin
      case ((i * 4) / text_q.size())
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
        default: begin send_idle_pct = 21; recv_stall_pct = 21; end
      endcase
      send_item(1'b0, text_q[i]);
    end
    // End of input inside an undecided markup lookahead, then items to be ignored.
    add_text("<!doc");
    foreach (text_q[i]) if (i >= text_q.size() - 5) send_item(1'b0, text_q[i]);
    send_item(1'b1, 8'h00);
    send_item(1'b0, 8'hA5);
    send_item(1'b1, 8'h5A);
    s_axis_tvalid_i <= 1'b0;

    @(posedge clk_i);
    wait (pending == 0);
    repeat (30) @(posedge clk_i);
    $display("Sent %0d input items (markup fragments, noise, end of input);", items_sent);
    $display("checked %0d token events under four idle and stall mixes.", events_seen);
    if (fail_count == 0) $display("html_tokenizer_byte_fsm_test: done, clean");
    else $display("html_tokenizer_byte_fsm_test: done, errors");
    $finish;
  end

endmodule
